@@ hw/rtl/sspq_pkg.sv @@
// ---------------------------------------------------------------------------
// sspq_pkg
// Shared types and constants for the stable sorted priority queue.
// ---------------------------------------------------------------------------
package sspq_pkg;

  localparam int VALUE_W = 32;
  localparam int PRIO_W  = 8;
  localparam int OCC_W   = 5;

  // Operation codes on the input channel
  typedef enum logic {
    OP_ENQ = 1'b0,
    OP_DEQ = 1'b1
  } op_t;

  // Result status codes
  typedef enum logic [1:0] {
    ST_ENQ   = 2'd0,
    ST_DEQ   = 2'd1,
    ST_EMPTY = 2'd2,
    ST_FULL  = 2'd3
  } status_t;

  // One stored entry
  typedef struct packed {
    logic [PRIO_W-1:0]         prio;
    logic signed [VALUE_W-1:0] value;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  // Sequencer states
  typedef enum logic [2:0] {
    S_IDLE,
    S_DEQ_RD,
    S_ENQ_STEP,
    S_ENQ_CMP,
    S_RESP
  } state_t;

endpackage

@@ hw/rtl/sspq_if.sv @@
// ---------------------------------------------------------------------------
// sspq_in_if / sspq_out_if
// Valid/ready channels carrying queue commands and queue results.
// ---------------------------------------------------------------------------
interface sspq_in_if
  import sspq_pkg::*;
  ();
  logic                      valid;
  logic                      ready;
  logic                      op;
  logic signed [VALUE_W-1:0] value_in;
  logic [PRIO_W-1:0]         prio_in;

  modport source (output valid, output op, output value_in, output prio_in, input ready);
  modport sink   (input valid, input op, input value_in, input prio_in, output ready);
endinterface

interface sspq_out_if
  import sspq_pkg::*;
  ();
  logic                      valid;
  logic                      ready;
  logic signed [VALUE_W-1:0] value_out;
  logic [1:0]                status;
  logic [OCC_W-1:0]          occupancy;

  modport source (output valid, output value_out, output status, output occupancy,
                  input ready);
  modport sink   (input valid, input value_out, input status, input occupancy,
                  output ready);
endinterface

@@ hw/rtl/sspq_ram.sv @@
// ---------------------------------------------------------------------------
// sspq_ram
// Generic single-write, single-read RAM with registered read data.
// ---------------------------------------------------------------------------
module sspq_ram #(
  parameter int WIDTH = 40,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

@@ hw/rtl/stable_sorted_priority_queue_top.sv @@
// ---------------------------------------------------------------------------
// stable_sorted_priority_queue_top
// Bounded priority queue kept sorted in a circular entry RAM; higher
// priority leaves first, equal priorities leave in arrival order.
// ---------------------------------------------------------------------------
// Channel   Dir  Handshake     Payload
// in_ch     in   valid/ready   op, value_in, prio_in
// out_ch    out  valid/ready   value_out, status, occupancy
//
// Dequeue pops the front entry. Enqueue walks back from the tail, moving
// each lower-priority entry back one slot, and stops when all have moved
// or behind an entry of greater or equal priority. Each moved entry costs
// one RAM read and one compare plus write, through the single read port
// and one priority comparator. Empty dequeue and full enqueue go straight
// to the response. Reset (rst_n low, sync) empties the queue; no clearing
// pass is needed. in_ch.ready is high only when the sequencer is idle; a
// waiting result holds in the output register.
// ---------------------------------------------------------------------------
module stable_sorted_priority_queue_top
  import sspq_pkg::*;
#(
  parameter int DEPTH = 16
) (
  input  logic         clk,
  input  logic         rst_n,
  sspq_in_if.sink      in_ch,
  sspq_out_if.source   out_ch
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam int SW = PW + 1;

  state_t state_r, state_nxt;

  logic [PW-1:0] head_r, head_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic [PW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [CW-1:0] left_r, left_nxt;
  entry_t        new_r, new_nxt;
  logic signed [VALUE_W-1:0] res_value_r, res_value_nxt;
  status_t       res_status_r, res_status_nxt;

  logic                      out_valid_r, out_valid_nxt;
  logic signed [VALUE_W-1:0] out_value_r, out_value_nxt;
  status_t                   out_status_r, out_status_nxt;
  logic [OCC_W-1:0]          out_occ_r, out_occ_nxt;

  logic          ram_wr_en;
  logic [PW-1:0] ram_wr_addr;
  entry_t        ram_wr_data;
  logic          ram_rd_en;
  logic [PW-1:0] ram_rd_addr;
  logic [ENTRY_W-1:0] ram_rd_bits;
  entry_t        rd_entry;

  logic          accept;
  logic          out_free;
  logic [SW-1:0] tail_sum;
  logic [PW-1:0] tail_ptr;
  logic [PW-1:0] head_inc;
  logic [PW-1:0] wr_dec;
  logic [31:0]   count_ext;

  // Entry storage
  sspq_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk     (clk),
    .wr_en   (ram_wr_en),
    .wr_addr (ram_wr_addr),
    .wr_data (ram_wr_data),
    .rd_en   (ram_rd_en),
    .rd_addr (ram_rd_addr),
    .rd_data (ram_rd_bits)
  );

  assign rd_entry = entry_t'(ram_rd_bits);

  // Handshake
  assign in_ch.ready = (state_r == S_IDLE);
  assign accept      = in_ch.valid && in_ch.ready;
  assign out_free    = !out_valid_r || out_ch.ready;

  // Circular pointer arithmetic
  assign tail_sum = SW'(head_r) + SW'(count_r);
  assign tail_ptr = (tail_sum >= SW'(DEPTH)) ? PW'(tail_sum - SW'(DEPTH)) : PW'(tail_sum);
  assign head_inc = (head_r == PW'(DEPTH - 1)) ? '0 : head_r + PW'(1);
  assign wr_dec   = (wr_ptr_r == '0) ? PW'(DEPTH - 1) : wr_ptr_r - PW'(1);
  assign count_ext = 32'(count_r);

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          if (op_t'(in_ch.op) == OP_DEQ) begin
            state_nxt = (count_r == '0) ? S_RESP : S_DEQ_RD;
          end else begin
            state_nxt = (count_r == CW'(DEPTH)) ? S_RESP : S_ENQ_STEP;
          end
        end
      end
      S_DEQ_RD:   state_nxt = S_RESP;
      S_ENQ_STEP: state_nxt = (left_r == '0) ? S_RESP : S_ENQ_CMP;
      S_ENQ_CMP: begin
        if (rd_entry.prio < new_r.prio) begin
          state_nxt = S_ENQ_STEP;
        end else begin
          state_nxt = S_RESP;
        end
      end
      S_RESP: begin
        if (out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // Datapath and RAM control
  always_comb begin
    head_nxt       = head_r;
    count_nxt      = count_r;
    wr_ptr_nxt     = wr_ptr_r;
    left_nxt       = left_r;
    new_nxt        = new_r;
    res_value_nxt  = res_value_r;
    res_status_nxt = res_status_r;
    out_valid_nxt  = out_valid_r && !out_ch.ready;
    out_value_nxt  = out_value_r;
    out_status_nxt = out_status_r;
    out_occ_nxt    = out_occ_r;
    ram_wr_en      = 1'b0;
    ram_wr_addr    = wr_ptr_r;
    ram_wr_data    = new_r;
    ram_rd_en      = 1'b0;
    ram_rd_addr    = head_r;

    case (state_r)
      // Take a transaction and set up its walk
      S_IDLE: begin
        if (accept) begin
          new_nxt.value = in_ch.value_in;
          new_nxt.prio  = in_ch.prio_in;
          res_value_nxt = '0;
          if (op_t'(in_ch.op) == OP_DEQ) begin
            if (count_r == '0) begin
              res_status_nxt = ST_EMPTY;
            end else begin
              ram_rd_en = 1'b1;
            end
          end else begin
            if (count_r == CW'(DEPTH)) begin
              res_status_nxt = ST_FULL;
            end
            wr_ptr_nxt = tail_ptr;
            left_nxt   = count_r;
          end
        end
      end
      // Pop the front entry
      S_DEQ_RD: begin
        res_value_nxt  = rd_entry.value;
        res_status_nxt = ST_DEQ;
        head_nxt       = head_inc;
        count_nxt      = count_r - CW'(1);
      end
      // Place the new entry, or fetch the entry in front of the hole
      S_ENQ_STEP: begin
        if (left_r == '0) begin
          ram_wr_en      = 1'b1;
          count_nxt      = count_r + CW'(1);
          res_status_nxt = ST_ENQ;
        end else begin
          ram_rd_en   = 1'b1;
          ram_rd_addr = wr_dec;
        end
      end
      // Move a lower-priority entry back, or drop the new one into the hole
      S_ENQ_CMP: begin
        ram_wr_en = 1'b1;
        if (rd_entry.prio < new_r.prio) begin
          ram_wr_data = rd_entry;
          wr_ptr_nxt  = wr_dec;
          left_nxt    = left_r - CW'(1);
        end else begin
          count_nxt      = count_r + CW'(1);
          res_status_nxt = ST_ENQ;
        end
      end
      // Hand the result to the output register
      S_RESP: begin
        if (out_free) begin
          out_valid_nxt  = 1'b1;
          out_value_nxt  = res_value_r;
          out_status_nxt = res_status_r;
          out_occ_nxt    = count_ext[OCC_W-1:0];
        end
      end
      default: begin
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      head_r      <= '0;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      head_r      <= head_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    wr_ptr_r     <= wr_ptr_nxt;
    left_r       <= left_nxt;
    new_r        <= new_nxt;
    res_value_r  <= res_value_nxt;
    res_status_r <= res_status_nxt;
    out_value_r  <= out_value_nxt;
    out_status_r <= out_status_nxt;
    out_occ_r    <= out_occ_nxt;
  end

  // Result channel
  assign out_ch.valid     = out_valid_r;
  assign out_ch.value_out = out_value_r;
  assign out_ch.status    = out_status_r;
  assign out_ch.occupancy = out_occ_r;

endmodule
